### rtl/aes_pkg.sv
// Package with AES-128 types, constants and byte-level functions.
package aes_pkg;

    localparam int NUM_ROUNDS_DEF = 10;
    localparam int DATA_W         = 64;
    localparam int BLOCK_W        = 128;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LOW   = 2'd3;

    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEYGEN,
        ST_INIT,
        ST_ROUND,
        ST_LAST,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } kexp_ctrl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte k of a 128-bit block, byte 0 in the top bits.
    function automatic logic [7:0] blk_byte(input logic [BLOCK_W-1:0] s, input int k);
        blk_byte = s[BLOCK_W-1-8*k -: 8];
    endfunction

endpackage

### rtl/aes_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module aes_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 22
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/aes_kexp.sv
// Iterative AES-128 key expansion, writing each round key to two RAM addresses.
module aes_kexp import aes_pkg::*; #(
    parameter int NUM_ROUNDS = NUM_ROUNDS_DEF,
    parameter int RK_ENTRIES = 2 * (NUM_ROUNDS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [BLOCK_W-1:0]            key,
    output kexp_ctrl_t                    ctrl,
    output logic                          we,
    output logic [$clog2(RK_ENTRIES)-1:0] waddr,
    output logic [BLOCK_W-1:0]            wkey
);

    localparam int RW = $clog2(NUM_ROUNDS + 2);
    localparam int WAW = $clog2(RK_ENTRIES);

    logic [RW-1:0]      rnd_reg, rnd_next;
    logic               busy_reg, busy_next;
    logic [7:0]         rc_reg, rc_next;
    logic [BLOCK_W-1:0] rk_reg, rk_next;
    logic [31:0]        t;
    logic [31:0]        w0, w1, w2, w3;
    logic               half_reg;

    always_comb
    begin
        t  = {SBOX[rk_reg[23:16]], SBOX[rk_reg[15:8]], SBOX[rk_reg[7:0]], SBOX[rk_reg[31:24]]}
             ^ {rc_reg, 24'd0};
        w0 = rk_reg[127:96] ^ t;
        w1 = rk_reg[95:64] ^ w0;
        w2 = rk_reg[63:32] ^ w1;
        w3 = rk_reg[31:0] ^ w2;
    end

    // Each round key is written whole, as one 128-bit word, at two addresses in turn.
    always_comb
    begin
        busy_next = busy_reg;
        rnd_next  = rnd_reg;
        rc_next   = rc_reg;
        rk_next   = rk_reg;
        if (start)
        begin
            busy_next = 1'b1;
            rnd_next  = '0;
            rc_next   = 8'h01;
            rk_next   = key;
        end
        else if (busy_reg && half_reg)
        begin
            if (rnd_reg == RW'(NUM_ROUNDS))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                rnd_next = rnd_reg + 1'b1;
                rc_next  = xtime(rc_reg);
                rk_next  = {w0, w1, w2, w3};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            half_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            rnd_reg  <= rnd_next;
            half_reg <= (start || !busy_reg) ? 1'b0 : !half_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rc_reg <= rc_next;
        rk_reg <= rk_next;
    end

    assign ctrl.start = start;
    assign ctrl.busy  = busy_reg;
    assign we    = busy_reg && !start;
    assign waddr = WAW'({rnd_reg, half_reg});
    assign wkey  = rk_reg;

endmodule

### rtl/aes128_cbc_block_cipher_top.sv
// Top level of the AES-128 CBC block cipher.
//
// Input stream s_axis: tdata carries data_high (bits 63:0) and data_low
// (bits 127:64); tuser carries action (bit 0) and first_block (bit 1).
// Output stream m_axis: tdata carries result_high (63:0), result_low (127:64).
// Config channel cfg_valid/cfg_ready writes key_high, key_low, iv_high, iv_low
// at indexes 0 to 3.
//
// After reset, and after every key write, the round keys are rebuilt: a
// start pulse and then the key expansion writes, during which no input is
// accepted. From acceptance, a block passes a load state, the initial key
// addition, NUM_ROUNDS rounds on the single round unit and an output state
// before its result is valid, each round key being read from the key RAM in
// the state before its use. The result is held until taken; s_axis_tready
// stays low while a result waits or a block is in work, so one block is in
// flight and a new block is not accepted until the last result is taken.
// The chain value resets to zero and reloads from the IV on first_block.
module aes128_cbc_block_cipher_top import aes_pkg::*; #(
    parameter int NUM_ROUNDS = NUM_ROUNDS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BLOCK_W-1:0]   s_axis_tdata,  // data_high, data_low
    input  logic [1:0]           s_axis_tuser,  // action, first_block
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [BLOCK_W-1:0]   m_axis_tdata,  // result_high, result_low
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    localparam int RK_ENTRIES = NUM_ROUNDS + 1;
    localparam int AW = $clog2(RK_ENTRIES);
    localparam int RW = $clog2(NUM_ROUNDS + 1);

    state_t state_reg, state_next;

    logic [BLOCK_W-1:0] key_reg, iv_reg, chain_reg, din_reg, st_reg, st_next, res_reg;
    logic               act_reg, kick_reg, ovalid_reg;
    logic [RW-1:0]      rnd_reg, rnd_next;
    kexp_ctrl_t         kctrl;
    logic               kwe;
    logic [$clog2(2*(NUM_ROUNDS+1))-1:0] kwaddr;
    logic [BLOCK_W-1:0] kwkey, rk;
    logic [AW-1:0]      raddr;
    logic               in_acc, cfg_acc, key_wr;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign cfg_acc = cfg_valid && cfg_ready;
    assign key_wr  = cfg_acc && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);
    assign cfg_ready = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE) && !ovalid_reg && !kick_reg && !kctrl.busy;

    aes_kexp #(.NUM_ROUNDS(NUM_ROUNDS)) u_kexp (
        .clk(clk), .rst_n(rst_n), .start(kick_reg), .key(key_reg),
        .ctrl(kctrl), .we(kwe), .waddr(kwaddr), .wkey(kwkey)
    );

    // The whole round key goes in one RAM word; write once per key pair.
    aes_ram #(.WIDTH(BLOCK_W), .DEPTH(RK_ENTRIES)) u_rk_ram (
        .clk(clk), .we(kwe && kwaddr[0]), .waddr(AW'(kwaddr >> 1)),
        .wdata(kwkey), .raddr(raddr), .rdata(rk)
    );

    // Round key address, set in the state before the key is used.
    always_comb
    begin
        raddr = '0;
        case (state_reg)
            ST_KEYGEN: raddr = (act_reg == ACT_ENCRYPT) ? '0 : AW'(NUM_ROUNDS);
            ST_INIT:   raddr = (act_reg == ACT_ENCRYPT) ? AW'(1) : AW'(NUM_ROUNDS - 1);
            ST_ROUND:  raddr = (act_reg == ACT_ENCRYPT) ? AW'(rnd_reg) + AW'(2)
                                                        : AW'(NUM_ROUNDS - 2) - AW'(rnd_reg);
            default:   raddr = '0;
        endcase
    end

    function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s,
                                                     input logic inv);
        logic [BLOCK_W-1:0] o;
        int c, r;
        o = '0;
        for (c = 0; c < 4; c++)
            for (r = 0; r < 4; r++)
                if (!inv)
                    o[BLOCK_W-1-8*(c*4+r) -: 8] = SBOX[blk_byte(s, ((c+r)%4)*4+r)];
                else
                    o[BLOCK_W-1-8*(((c+r)%4)*4+r) -: 8] = INV_SBOX[blk_byte(s, c*4+r)];
        return o;
    endfunction

    function automatic logic [BLOCK_W-1:0] mix(input logic [BLOCK_W-1:0] s,
                                               input logic inv);
        logic [BLOCK_W-1:0] o;
        logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, u, v;
        int c;
        o = '0;
        for (c = 0; c < 4; c++)
        begin
            a0 = blk_byte(s, 4*c);
            a1 = blk_byte(s, 4*c+1);
            a2 = blk_byte(s, 4*c+2);
            a3 = blk_byte(s, 4*c+3);
            if (inv)
            begin
                u  = xtime(xtime(a0 ^ a2));
                v  = xtime(xtime(a1 ^ a3));
                a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
            end
            x0 = a0 ^ a1; x1 = a1 ^ a2; x2 = a2 ^ a3; x3 = a3 ^ a0;
            u  = a0 ^ a1 ^ a2 ^ a3;
            o[BLOCK_W-1-32*c -: 32] = {a0 ^ u ^ xtime(x0), a1 ^ u ^ xtime(x1),
                                      a2 ^ u ^ xtime(x2), a3 ^ u ^ xtime(x3)};
        end
        return o;
    endfunction

    // Shared round unit.
    always_comb
    begin
        st_next = st_reg;
        case (state_reg)
            ST_INIT:  st_next = st_reg ^ rk;
            ST_ROUND:
                if (act_reg == ACT_ENCRYPT)
                    st_next = mix(sub_shift(st_reg, 1'b0), 1'b0) ^ rk;
                else
                    st_next = mix(sub_shift(st_reg, 1'b1) ^ rk, 1'b1);
            ST_LAST:  st_next = sub_shift(st_reg, act_reg) ^ rk;
            default:  st_next = st_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        case (state_reg)
            ST_IDLE:   if (in_acc) state_next = ST_KEYGEN;
            ST_KEYGEN: state_next = ST_INIT;
            ST_INIT:
            begin
                rnd_next   = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == RW'(NUM_ROUNDS - 2))
                    state_next = ST_LAST;
            end
            ST_LAST:   state_next = ST_OUT;
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            kick_reg   <= 1'b1;
            ovalid_reg <= 1'b0;
            key_reg    <= '0;
            iv_reg     <= '0;
            chain_reg  <= '0;
            rnd_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            kick_reg  <= key_wr;
            if (cfg_acc)
            begin
                case (cfg_index)
                    REG_KEY_HIGH: key_reg[127:64] <= cfg_data;
                    REG_KEY_LOW:  key_reg[63:0]   <= cfg_data;
                    REG_IV_HIGH:  iv_reg[127:64]  <= cfg_data;
                    REG_IV_LOW:   iv_reg[63:0]    <= cfg_data;
                    default:      ;
                endcase
            end
            if (in_acc && s_axis_tuser[1])
                chain_reg <= iv_reg;
            if (state_reg == ST_OUT)
            begin
                ovalid_reg <= 1'b1;
                chain_reg  <= (act_reg == ACT_ENCRYPT) ? st_reg : din_reg;
            end
            else if (m_axis_tvalid && m_axis_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            act_reg <= s_axis_tuser[0];
            din_reg <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
        end
        if (state_reg == ST_KEYGEN)
            st_reg <= (act_reg == ACT_ENCRYPT) ? din_reg ^ chain_reg : din_reg;
        else
            st_reg <= st_next;
        if (state_reg == ST_OUT)
            res_reg <= (act_reg == ACT_ENCRYPT) ? st_reg : st_reg ^ chain_reg;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {res_reg[63:0], res_reg[127:64]};

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("input accepted while a block is in work");
    a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |=> m_axis_tvalid)
        else $error("result not shown after final round");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

### dv/tb_top.sv
// Testbench for the AES-128 CBC block cipher: directed vectors and chained random messages.
`timescale 1ns / 1ps

module tb_top import aes_pkg::*; ();

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [BLOCK_W-1:0]   s_axis_tdata;   // data_high, data_low
    logic [1:0]           s_axis_tuser;   // action, first_block
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [BLOCK_W-1:0]   m_axis_tdata;   // result_high, result_low
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    aes128_cbc_block_cipher_top u_dut (.*);

    // Cipher state kept alongside the block.
    logic [DATA_W-1:0]  key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
    logic [BLOCK_W-1:0] chain_q;
    logic [7:0]         rk_bytes [0:10][0:15];

    logic [BLOCK_W-1:0] expected_blocks [$];
    bit                 failed;
    bit                 idle_on;
    int                 out_stall;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [7:0] gf_double(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = gf_double(a);
        end
        return p;
    endfunction

    function automatic void build_round_keys();
        logic [31:0] w [0:43];
        logic [31:0] t;
        logic [7:0]  rcon;
        rcon = 8'h01;
        w[0] = key_hi_q[63:32];
        w[1] = key_hi_q[31:0];
        w[2] = key_lo_q[63:32];
        w[3] = key_lo_q[31:0];
        for (int i = 4; i < 44; i++)
        begin
            t = w[i-1];
            if (i % 4 == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
                t ^= {rcon, 24'h0};
                rcon = gf_double(rcon);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r <= 10; r++)
            for (int k = 0; k < 16; k++)
                rk_bytes[r][k] = w[4*r + k/4][31 - 8*(k%4) -: 8];
    endfunction

    // Bytes map into the state column by column: byte k is row k%4 of column k/4.
    function automatic logic [BLOCK_W-1:0] cipher_block(input logic [BLOCK_W-1:0] blk,
                                                        input bit decrypt);
        logic [7:0] s [0:15];
        logic [7:0] o [0:15];
        logic [7:0] m [0:3];
        logic [BLOCK_W-1:0] res;
        int r;
        for (int k = 0; k < 16; k++)
            s[k] = blk[127 - 8*k -: 8] ^ rk_bytes[decrypt ? 10 : 0][k];
        for (int step = 1; step <= 10; step++)
        begin
            r = decrypt ? 10 - step : step;
            o = s;
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++)
                    if (decrypt)
                        s[((c + w) % 4)*4 + w] = INV_SBOX[o[c*4 + w]];
                    else
                        s[c*4 + w] = SBOX[o[((c + w) % 4)*4 + w]];
            if (!decrypt && step != 10)
                m = '{8'd2, 8'd3, 8'd1, 8'd1};
            else
                m = '{8'd14, 8'd11, 8'd13, 8'd9};
            // Forward rounds mix before the key add, inverse rounds after it.
            if (decrypt)
                for (int k = 0; k < 16; k++)
                    s[k] ^= rk_bytes[r][k];
            if (step != 10)
            begin
                o = s;
                for (int c = 0; c < 4; c++)
                    for (int w = 0; w < 4; w++)
                        s[4*c + w] = gf_product(o[4*c + w], m[0])
                                   ^ gf_product(o[4*c + (w + 1) % 4], m[1])
                                   ^ gf_product(o[4*c + (w + 2) % 4], m[2])
                                   ^ gf_product(o[4*c + (w + 3) % 4], m[3]);
            end
            if (!decrypt)
                for (int k = 0; k < 16; k++)
                    s[k] ^= rk_bytes[r][k];
        end
        for (int k = 0; k < 16; k++)
            res[127 - 8*k -: 8] = s[k];
        return res;
    endfunction

    function automatic void predict_block(input logic action, input logic first,
                                          input logic [BLOCK_W-1:0] blk);
        logic [BLOCK_W-1:0] res;
        if (first)
            chain_q = {iv_hi_q, iv_lo_q};
        if (action == ACT_ENCRYPT)
        begin
            res = cipher_block(blk ^ chain_q, 1'b0);
            chain_q = res;
        end
        else
        begin
            res = cipher_block(blk, 1'b1) ^ chain_q;
            chain_q = blk;
        end
        expected_blocks = {expected_blocks, res};
    endfunction

    // Result checker.
    always @(posedge clk)
    begin
        logic [BLOCK_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_blocks.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, m_axis_tdata);
                failed = 1'b1;
            end
            else
            begin
                want = expected_blocks.pop_front();
                if (m_axis_tdata[63:0] !== want[127:64])
                begin
                    $display("%0t: result_high expected %h actual %h", $realtime,
                             want[127:64], m_axis_tdata[63:0]);
                    failed = 1'b1;
                end
                if (m_axis_tdata[127:64] !== want[63:0])
                begin
                    $display("%0t: result_low expected %h actual %h", $realtime,
                             want[63:0], m_axis_tdata[127:64]);
                    failed = 1'b1;
                end
            end
        end
    end

    // Output back-pressure in random bursts.
    always @(negedge clk)
    begin
        if (idle_on && out_stall > 0)
        begin
            out_stall <= out_stall - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            out_stall <= $urandom_range(0, 12);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_block(input logic action, input logic first,
                              input logic [63:0] hi, input logic [63:0] lo);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lo, hi};
        s_axis_tuser  <= {first, action};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_block(action, first, {hi, lo});
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_blocks.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_KEY_HIGH: key_hi_q = val;
            REG_KEY_LOW:  key_lo_q = val;
            REG_IV_HIGH:  iv_hi_q  = val;
            default:      iv_lo_q  = val;
        endcase
        if (idx == REG_KEY_HIGH || idx == REG_KEY_LOW)
            build_round_keys();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_key_iv(input logic [63:0] kh, input logic [63:0] kl,
                              input logic [63:0] ih, input logic [63:0] il);
        drain();
        write_reg(REG_KEY_HIGH, kh);
        write_reg(REG_KEY_LOW, kl);
        write_reg(REG_IV_HIGH, ih);
        write_reg(REG_IV_LOW, il);
    endtask

    task automatic test_after_reset();
        // No first block yet: chaining starts from zero under the all-zero key.
        send_block(ACT_ENCRYPT, 1'b0, '0, '0);
        send_block(ACT_DECRYPT, 1'b0, '1, '1);
        send_block(ACT_ENCRYPT, 1'b0, 64'h8000000000000001, 64'h0123456789abcdef);
    endtask

    task automatic test_known_vector();
        set_key_iv(64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0);
        send_block(ACT_ENCRYPT, 1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(ACT_DECRYPT, 1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        set_key_iv('1, '1, '1, '1);
        send_block(ACT_ENCRYPT, 1'b1, '1, '1);
        send_block(ACT_ENCRYPT, 1'b0, '0, '0);
        send_block(ACT_DECRYPT, 1'b1, '0, '0);
        send_block(ACT_DECRYPT, 1'b0, '1, '1);
    endtask

    task automatic test_mid_message_writes();
        send_block(ACT_ENCRYPT, 1'b1, rand64(), rand64());
        // A new IV waits for the next first block; the chain carries on.
        drain();
        write_reg(REG_IV_HIGH, rand64());
        write_reg(REG_IV_LOW, rand64());
        send_block(ACT_ENCRYPT, 1'b0, rand64(), rand64());
        send_block(ACT_ENCRYPT, 1'b1, rand64(), rand64());
        // A new key applies at once and keeps the chain.
        drain();
        write_reg(REG_KEY_LOW, rand64());
        send_block(ACT_ENCRYPT, 1'b0, rand64(), rand64());
        send_block(ACT_DECRYPT, 1'b0, rand64(), rand64());
        drain();
        write_reg(REG_KEY_HIGH, rand64());
        send_block(ACT_DECRYPT, 1'b0, rand64(), rand64());
    endtask

    task automatic test_random_messages(input int n_blocks);
        int sent;
        int len;
        logic act;
        sent = 0;
        while (sent < n_blocks)
        begin
            if ($urandom_range(0, 14) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: set_key_iv('0, '0, '0, '0);
                    1: set_key_iv('1, '1, '1, '1);
                    default: set_key_iv(rand64(), rand64(), rand64(), rand64());
                endcase
            end
            len = $urandom_range(1, 8);
            act = 1'($urandom_range(0, 1));
            for (int i = 0; i < len; i++)
            begin
                // Most messages keep one direction; some mix or restart mid-way.
                send_block($urandom_range(0, 9) == 0 ? ~act : act,
                           i == 0 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0),
                           rand64(), rand64());
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_KEY_HIGH;
        cfg_data = '0;
        failed = 1'b0;
        idle_on = 1'b1;
        out_stall = 0;
        key_hi_q = '0;
        key_lo_q = '0;
        iv_hi_q = '0;
        iv_lo_q = '0;
        chain_q = '0;
        build_round_keys();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_after_reset();
        test_known_vector();
        test_mid_message_writes();
        test_random_messages(1130);
        idle_on = 1'b0;
        test_random_messages(100);
        drain();

        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
